### hdl/point_box_signed_distance_assert.svh
// Assertion macros for the point to box signed distance block.
`ifndef POINT_BOX_SIGNED_DISTANCE_ASSERT_SVH
`define POINT_BOX_SIGNED_DISTANCE_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define PBSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define PBSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pbsd_pkg.sv
// Shared types and constants for the point to box signed distance block.
package pbsd_pkg;

    localparam int NUM_SIDES  = 6;
    localparam int OUT_TDATA_W = 72;

    localparam logic [2:0] REG_INSIDE_MODE = 3'd6;

    localparam logic [15:0] SD_MAX = 16'h7FFF;
    localparam logic [15:0] SD_MIN = 16'h8000;

    typedef struct packed {
        logic               found;
        logic [2:0]         idx;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } side_t;

    typedef struct packed {
        logic  all_neg;
        logic  all_pos;
        side_t neg;
        side_t pos;
    } track_t;

endpackage

### hdl/point_box_signed_distance.sv
// Point to box signed distance over six configured planes: top level.
//
// Usage:
//   s_tdata carries one point per item; m_tdata and m_tuser carry one
//   result per point, in order. Planes and inside_mode are written through
//   cfg_we / cfg_addr / cfg_wdata while no item is in flight; index 0..5
//   selects a side plane, index 6 the mode bit, index 7 is ignored.
//   The point travels down a row of six cells, one per side. Each cell
//   registers three products, then the distance and the update of the
//   nearest negative and nearest positive side found so far.
//   Throughput: one item per cycle while the receiver does not stall.
//   A stalled receiver holds the output register; upstream stages keep
//   accepting until every stage holds an item, then s_tready drops.
//   Reset clears all planes, inside_mode and every valid flag.
//   When no side qualifies, m_tuser is 0 and m_tdata is all zero.
module point_box_signed_distance #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_addr,
    input  logic [63:0]                         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // point_x, point_y, point_z, zero pad
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // signed_distance, normal_x, normal_y, normal_z, side_index, zero pad
    output logic [pbsd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // valid_res
    output logic                                m_tuser
);

    localparam int DW = COORD_WIDTH + 20;
    localparam int NS = pbsd_pkg::NUM_SIDES;

    logic [63:0] plane_reg [NS];
    logic        inside_mode_reg;

    logic                          link_valid [NS+1];
    logic                          link_ready [NS+1];
    logic signed [COORD_WIDTH-1:0] link_x     [NS+1];
    logic signed [COORD_WIDTH-1:0] link_y     [NS+1];
    logic signed [COORD_WIDTH-1:0] link_z     [NS+1];
    pbsd_pkg::track_t              link_track [NS+1];
    logic signed [DW-1:0]          link_neg_d [NS+1];
    logic signed [DW-1:0]          link_pos_d [NS+1];

    logic signed [15:0] signed_distance;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [2:0]         side_index;
    logic               valid_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                plane_reg[k] <= '0;
            end
            inside_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == pbsd_pkg::REG_INSIDE_MODE)
            begin
                inside_mode_reg <= cfg_wdata[0];
            end
            else if (cfg_addr < pbsd_pkg::REG_INSIDE_MODE)
            begin
                plane_reg[cfg_addr] <= cfg_wdata;
            end
        end
    end

    assign link_valid[0] = s_tvalid;
    assign s_tready      = link_ready[0];
    assign link_x[0]     = s_tdata[COORD_WIDTH-1:0];
    assign link_y[0]     = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign link_z[0]     = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign link_track[0] = '{all_neg: 1'b1, all_pos: 1'b1, neg: '0, pos: '0};
    assign link_neg_d[0] = '0;
    assign link_pos_d[0] = '0;

    for (genvar i = 0; i < NS; i++)
    begin : g_cell
        pbsd_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .DIST_WIDTH  (DW),
            .SIDE_INDEX  (3'(i))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .plane     (plane_reg[i]),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_x      (link_x[i]),
            .in_y      (link_y[i]),
            .in_z      (link_z[i]),
            .in_track  (link_track[i]),
            .in_neg_d  (link_neg_d[i]),
            .in_pos_d  (link_pos_d[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_x     (link_x[i+1]),
            .out_y     (link_y[i+1]),
            .out_z     (link_z[i+1]),
            .out_track (link_track[i+1]),
            .out_neg_d (link_neg_d[i+1]),
            .out_pos_d (link_pos_d[i+1])
        );
    end

    pbsd_select #(
        .DIST_WIDTH (DW)
    ) u_select (
        .clk             (clk),
        .rst_n           (rst_n),
        .inside_mode     (inside_mode_reg),
        .in_valid        (link_valid[NS]),
        .in_ready        (link_ready[NS]),
        .in_track        (link_track[NS]),
        .in_neg_d        (link_neg_d[NS]),
        .in_pos_d        (link_pos_d[NS]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .signed_distance (signed_distance),
        .normal_x        (normal_x),
        .normal_y        (normal_y),
        .normal_z        (normal_z),
        .side_index      (side_index),
        .valid_res       (valid_res)
    );

    assign m_tdata = {5'b0, side_index, normal_z, normal_y, normal_x, signed_distance};
    assign m_tuser = valid_res;

`include "point_box_signed_distance_assert.svh"

    `PBSD_ASSERT_NOW(a_empty_zero, m_tvalid && !m_tuser, m_tdata == '0, "empty result not zero")
    `PBSD_ASSERT_NOW(a_side_range, m_tvalid && m_tuser, side_index <= 3'd5, "side index out of range")
    `PBSD_ASSERT_NOW(a_normal_match, m_tvalid && m_tuser && side_index <= 3'd5, m_tdata[63:16] == plane_reg[side_index][47:0], "normal differs from chosen plane")

endmodule

### hdl/pbsd_cell.sv
// One side of the box: plane distance and running nearest side update.
module pbsd_cell #(
    parameter int         COORD_WIDTH = 16,
    parameter int         DIST_WIDTH  = 36,
    parameter logic [2:0] SIDE_INDEX  = 3'd0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [63:0]                   plane,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [COORD_WIDTH-1:0] in_z,
    input  pbsd_pkg::track_t              in_track,
    input  logic signed [DIST_WIDTH-1:0]  in_neg_d,
    input  logic signed [DIST_WIDTH-1:0]  in_pos_d,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output pbsd_pkg::track_t              out_track,
    output logic signed [DIST_WIDTH-1:0]  out_neg_d,
    output logic signed [DIST_WIDTH-1:0]  out_pos_d
);

    localparam int PW = COORD_WIDTH + 16;

    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [15:0] off;

    logic signed [PW-1:0] prod_x;
    logic signed [PW-1:0] prod_y;
    logic signed [PW-1:0] prod_z;

    logic                          a_valid_reg;
    logic signed [COORD_WIDTH-1:0] a_x_reg;
    logic signed [COORD_WIDTH-1:0] a_y_reg;
    logic signed [COORD_WIDTH-1:0] a_z_reg;
    logic signed [PW-1:0]          a_prod_x_reg;
    logic signed [PW-1:0]          a_prod_y_reg;
    logic signed [PW-1:0]          a_prod_z_reg;
    pbsd_pkg::track_t              a_track_reg;
    logic signed [DIST_WIDTH-1:0]  a_neg_d_reg;
    logic signed [DIST_WIDTH-1:0]  a_pos_d_reg;

    logic                          b_valid_reg;
    logic signed [COORD_WIDTH-1:0] b_x_reg;
    logic signed [COORD_WIDTH-1:0] b_y_reg;
    logic signed [COORD_WIDTH-1:0] b_z_reg;
    pbsd_pkg::track_t              b_track_reg;
    pbsd_pkg::track_t              b_track_next;
    logic signed [DIST_WIDTH-1:0]  b_neg_d_reg;
    logic signed [DIST_WIDTH-1:0]  b_neg_d_next;
    logic signed [DIST_WIDTH-1:0]  b_pos_d_reg;
    logic signed [DIST_WIDTH-1:0]  b_pos_d_next;

    logic                          a_ready;
    logic                          b_ready;
    logic signed [DIST_WIDTH-1:0]  plane_d;
    pbsd_pkg::side_t               this_side;

    assign nx  = plane[15:0];
    assign ny  = plane[31:16];
    assign nz  = plane[47:32];
    assign off = plane[63:48];

    assign prod_x = $signed({{COORD_WIDTH{nx[15]}}, nx})
                  * $signed({{16{in_x[COORD_WIDTH-1]}}, in_x});
    assign prod_y = $signed({{COORD_WIDTH{ny[15]}}, ny})
                  * $signed({{16{in_y[COORD_WIDTH-1]}}, in_y});
    assign prod_z = $signed({{COORD_WIDTH{nz[15]}}, nz})
                  * $signed({{16{in_z[COORD_WIDTH-1]}}, in_z});

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign plane_d = $signed({{(DIST_WIDTH-PW){a_prod_x_reg[PW-1]}}, a_prod_x_reg})
                   + $signed({{(DIST_WIDTH-PW){a_prod_y_reg[PW-1]}}, a_prod_y_reg})
                   + $signed({{(DIST_WIDTH-PW){a_prod_z_reg[PW-1]}}, a_prod_z_reg})
                   - $signed({{(DIST_WIDTH-30){off[15]}}, off, 14'b0});

    assign this_side = '{found: 1'b1, idx: SIDE_INDEX, nx: nx, ny: ny, nz: nz};

    always_comb
    begin
        b_track_next = a_track_reg;
        b_neg_d_next = a_neg_d_reg;
        b_pos_d_next = a_pos_d_reg;
        if (plane_d < 0)
        begin
            b_track_next.all_pos = 1'b0;
            if (!a_track_reg.neg.found || plane_d > a_neg_d_reg)
            begin
                b_track_next.neg = this_side;
                b_neg_d_next     = plane_d;
            end
        end
        else if (plane_d > 0)
        begin
            b_track_next.all_neg = 1'b0;
            if (!a_track_reg.pos.found || plane_d < a_pos_d_reg)
            begin
                b_track_next.pos = this_side;
                b_pos_d_next     = plane_d;
            end
        end
        else
        begin
            b_track_next.all_neg = 1'b0;
            b_track_next.all_pos = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_x_reg      <= in_x;
            a_y_reg      <= in_y;
            a_z_reg      <= in_z;
            a_prod_x_reg <= prod_x;
            a_prod_y_reg <= prod_y;
            a_prod_z_reg <= prod_z;
            a_track_reg  <= in_track;
            a_neg_d_reg  <= in_neg_d;
            a_pos_d_reg  <= in_pos_d;
        end
        if (b_ready && a_valid_reg)
        begin
            b_x_reg     <= a_x_reg;
            b_y_reg     <= a_y_reg;
            b_z_reg     <= a_z_reg;
            b_track_reg <= b_track_next;
            b_neg_d_reg <= b_neg_d_next;
            b_pos_d_reg <= b_pos_d_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_x     = b_x_reg;
    assign out_y     = b_y_reg;
    assign out_z     = b_z_reg;
    assign out_track = b_track_reg;
    assign out_neg_d = b_neg_d_reg;
    assign out_pos_d = b_pos_d_reg;

endmodule

### hdl/pbsd_select.sv
// Side choice, rounding and saturation, and the output register.
module pbsd_select #(
    parameter int DIST_WIDTH = 36
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         inside_mode,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  pbsd_pkg::track_t             in_track,
    input  logic signed [DIST_WIDTH-1:0] in_neg_d,
    input  logic signed [DIST_WIDTH-1:0] in_pos_d,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [15:0]           signed_distance,
    output logic signed [15:0]           normal_x,
    output logic signed [15:0]           normal_y,
    output logic signed [15:0]           normal_z,
    output logic [2:0]                   side_index,
    output logic                         valid_res
);

    localparam int QW = DIST_WIDTH - 13;

    logic                         o_valid_reg;
    logic signed [15:0]           sd_reg;
    logic signed [15:0]           sd_next;
    pbsd_pkg::side_t              side_reg;
    pbsd_pkg::side_t              side_next;

    logic                         pick_neg;
    logic signed [DIST_WIDTH-1:0] d_pick;
    logic signed [DIST_WIDTH:0]   rnd;
    logic signed [QW-1:0]         q;

    assign in_ready = !o_valid_reg || out_ready;

    assign pick_neg = inside_mode ? !in_track.all_pos : in_track.all_neg;
    assign d_pick   = pick_neg ? in_neg_d : in_pos_d;
    assign rnd      = $signed({d_pick[DIST_WIDTH-1], d_pick}) + (DIST_WIDTH+1)'(8192);
    assign q        = rnd[DIST_WIDTH:14];

    always_comb
    begin
        side_next = pick_neg ? in_track.neg : in_track.pos;
        if (q[QW-1:15] == {(QW-15){q[15]}})
        begin
            sd_next = q[15:0];
        end
        else
        begin
            sd_next = q[QW-1] ? pbsd_pkg::SD_MIN : pbsd_pkg::SD_MAX;
        end
        if (!side_next.found)
        begin
            side_next = '0;
            sd_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            o_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sd_reg   <= sd_next;
            side_reg <= side_next;
        end
    end

    assign out_valid       = o_valid_reg;
    assign signed_distance = sd_reg;
    assign normal_x        = side_reg.nx;
    assign normal_y        = side_reg.ny;
    assign normal_z        = side_reg.nz;
    assign side_index      = side_reg.idx;
    assign valid_res       = side_reg.found;

endmodule
